@@ design/hbp_pkg.sv @@
// shared constants and types for the huffman bit packer
package hbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;

    localparam int SYM_W     = 8;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int BITS_W    = 4;
    localparam int BYTE_BITS = 8;

    localparam int IDX_W     = $clog2(SYMBOL_COUNT);
    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int FILL_W    = $clog2(BYTE_BITS);
    localparam int BUF_W     = BYTE_BITS - 1 + CODE_W;
    localparam int CNT_W     = $clog2(BUF_W + 1);

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_ENCODE = 1'b1
    } req_t;

endpackage

@@ design/huffman_bit_packer.sv @@
// Table-driven huffman encoder: code table, lookup stage and LSB-first byte packer.
//
// Input channel (s_valid/s_ready): a load request (s_req_type = 0) writes one code
// table entry and gives no result; an encode request (s_req_type = 1) looks up the
// code of s_data_byte and appends its bits to the byte accumulator. With
// s_end_of_data high, a partly filled byte is flushed with its bit count.
// Result channel (m_valid/m_ready): the packed bytes of each request, with m_bits_used,
// m_run_last on the last byte of a request and m_stream_last on the last byte of
// the stream.
// The first byte of an encode request passes the lookup stage (table read), the
// accumulator (packing) and then the output register.
// Throughput: a request is accepted every cycle while the results keep pace; a
// request that yields several bytes holds the packer until they are all sent, so the
// result port's one byte per cycle, while m_ready is high, sets the rate, up to five
// bytes for a 32-bit code with a flush.
// Reset clears the accumulator, both pipeline stages and the valid bit of every
// table entry, so no symbol has a code. When m_ready is low the output register
// holds its byte, the packer and the lookup stage fill up, and s_ready falls.
module huffman_bit_packer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_req_type,
    input  logic [hbp_pkg::SYM_W-1:0]  s_entry_symbol,
    input  logic [hbp_pkg::CODE_W-1:0] s_entry_code,
    input  logic [hbp_pkg::LEN_W-1:0]  s_entry_length,
    input  logic [hbp_pkg::SYM_W-1:0]  s_data_byte,
    input  logic                       s_end_of_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [hbp_pkg::BYTE_BITS-1:0] m_out_byte,
    output logic [hbp_pkg::BITS_W-1:0] m_bits_used,
    output logic                       m_run_last,
    output logic                       m_stream_last
);
    import hbp_pkg::*;

    // code table, codes stored in send order from bit 0
    logic [CODE_W-1:0]       code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] len_valid_reg;

    logic s_fire;
    logic is_load;
    logic is_encode;
    logic load_in_range;
    logic data_in_range;

    logic [LEN_W-1:0]  len_sat;
    logic [CODE_W-1:0] code_rev;
    logic [LEN_W:0]    rev_shift;
    logic [CODE_W-1:0] code_seq;

    // lookup stage
    logic              a_valid_reg;
    logic [CODE_W-1:0] a_seq_reg;
    logic [LEN_W-1:0]  a_len_reg;
    logic              a_eod_reg;
    logic              a_take;
    logic [CODE_W-1:0] a_seq_eff;

    // packer
    logic [BUF_W-1:0] buf_reg, buf_next, buf_after;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_after, cnt_rem;
    logic             eod_reg, eod_next;
    logic             b_full;
    logic             b_pending;
    logic             b_can_take;

    // output register
    logic                 out_free;
    logic                 emit;
    logic                 e_run_last;
    logic                 m_valid_reg;
    logic [BYTE_BITS-1:0] m_byte_reg;
    logic [BITS_W-1:0]    m_bits_reg;
    logic                 m_run_last_reg;
    logic                 m_stream_last_reg;

    assign s_fire        = s_valid && s_ready;
    assign is_load       = (req_t'(s_req_type) == REQ_LOAD);
    assign is_encode     = (req_t'(s_req_type) == REQ_ENCODE);
    assign load_in_range = ({1'b0, s_entry_symbol} < (SYM_W+1)'(SYMBOL_COUNT));
    assign data_in_range = ({1'b0, s_data_byte} < (SYM_W+1)'(SYMBOL_COUNT));

    // saturate the length and put the first bit sent at bit 0
    always_comb begin
        len_sat = (s_entry_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : s_entry_length;
        for (int i = 0; i < CODE_W; i++) begin
            code_rev[i] = s_entry_code[CODE_W-1-i];
        end
        rev_shift = (LEN_W+1)'(CODE_W) - {1'b0, len_sat};
        code_seq  = code_rev >> rev_shift;
    end

    always_ff @(posedge aclk) begin
        if (s_fire && is_load && load_in_range) begin
            code_mem[s_entry_symbol[IDX_W-1:0]] <= code_seq;
            len_mem[s_entry_symbol[IDX_W-1:0]]  <= len_sat;
        end
        if (s_fire && is_encode) begin
            a_seq_reg <= code_mem[s_data_byte[IDX_W-1:0]];
            if (data_in_range && len_valid_reg[s_data_byte[IDX_W-1:0]]) begin
                a_len_reg <= len_mem[s_data_byte[IDX_W-1:0]];
            end else begin
                a_len_reg <= '0;
            end
            a_eod_reg <= s_end_of_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_valid_reg <= '0;
        end else if (s_fire && is_load && load_in_range) begin
            len_valid_reg[s_entry_symbol[IDX_W-1:0]] <= 1'b1;
        end
    end

    // entries never written have no valid length, so their code is masked
    assign a_seq_eff = (a_len_reg == '0) ? '0 : a_seq_reg;

    // packer: emit a full byte, or the flush, then merge the next code
    always_comb begin
        b_full     = (cnt_reg >= CNT_W'(BYTE_BITS));
        b_pending  = b_full || (eod_reg && (cnt_reg != '0));
        out_free   = !m_valid_reg || m_ready;
        emit       = b_pending && out_free;
        cnt_rem    = cnt_reg - CNT_W'(BYTE_BITS);
        e_run_last = b_full ? !((cnt_rem >= CNT_W'(BYTE_BITS)) || (eod_reg && (cnt_rem != '0)))
                            : 1'b1;

        buf_after = buf_reg;
        cnt_after = cnt_reg;
        if (emit) begin
            if (b_full) begin
                buf_after = buf_reg >> BYTE_BITS;
                cnt_after = cnt_rem;
            end else begin
                buf_after = '0;
                cnt_after = '0;
            end
        end

        b_can_take = !b_pending || (emit && e_run_last);
        a_take     = a_valid_reg && b_can_take;

        buf_next = buf_after;
        cnt_next = cnt_after;
        eod_next = eod_reg;
        if (a_take) begin
            buf_next = buf_after | (BUF_W'(a_seq_eff) << cnt_after[FILL_W-1:0]);
            cnt_next = cnt_after + CNT_W'(a_len_reg);
            eod_next = a_eod_reg;
        end
    end

    // only encode requests move through the lookup stage
    assign s_ready = !a_valid_reg || a_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            buf_reg     <= '0;
            cnt_reg     <= '0;
            eod_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire && is_encode) begin
                a_valid_reg <= 1'b1;
            end else if (a_take) begin
                a_valid_reg <= 1'b0;
            end
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
            eod_reg <= eod_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_byte_reg        <= buf_reg[BYTE_BITS-1:0];
            m_bits_reg        <= b_full ? BITS_W'(BYTE_BITS) : BITS_W'(cnt_reg);
            m_run_last_reg    <= e_run_last;
            m_stream_last_reg <= e_run_last && eod_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_bits_used   = m_bits_reg;
    assign m_run_last    = m_run_last_reg;
    assign m_stream_last = m_stream_last_reg;

endmodule

@@ design/hbp_checker.sv @@
// port-level checks for the huffman bit packer, bound to the top level
module hbp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [hbp_pkg::BYTE_BITS-1:0] m_out_byte,
    input logic [hbp_pkg::BITS_W-1:0]    m_bits_used,
    input logic                          m_run_last,
    input logic                          m_stream_last
);
    import hbp_pkg::*;

    // a stalled result keeps its byte
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_bits_used)
            && $stable(m_run_last) && $stable(m_stream_last))
        else $error("stalled result changed");

    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bits_used != '0) && (m_bits_used <= BITS_W'(BYTE_BITS)))
        else $error("bit count out of range");

    // a short byte only comes from the flush at the end of the stream
    a_short_is_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_bits_used != BITS_W'(BYTE_BITS)) |-> m_run_last && m_stream_last)
        else $error("short byte outside a flush");

    a_stream_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_last |-> m_run_last)
        else $error("stream end inside a request");

    // bits above the count stay clear
    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_bits_used < BITS_W'(BYTE_BITS)) |-> ((m_out_byte >> m_bits_used) == '0))
        else $error("unused bits set in flushed byte");

endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_byte    (m_out_byte),
    .m_bits_used   (m_bits_used),
    .m_run_last    (m_run_last),
    .m_stream_last (m_stream_last)
);

@@ tb/sv/hbp_stream_checker.sv @@
`timescale 1ns / 100ps
// checker for the huffman bit packer: watches both channels, predicts packed bytes and compares
module hbp_stream_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [hbp_pkg::SYM_W-1:0]     s_entry_symbol,
    input  logic [hbp_pkg::CODE_W-1:0]    s_entry_code,
    input  logic [hbp_pkg::LEN_W-1:0]     s_entry_length,
    input  logic [hbp_pkg::SYM_W-1:0]     s_data_byte,
    input  logic                          s_end_of_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [hbp_pkg::BYTE_BITS-1:0] m_out_byte,
    input  logic [hbp_pkg::BITS_W-1:0]    m_bits_used,
    input  logic                          m_run_last,
    input  logic                          m_stream_last,
    output int                            mismatches,
    output int                            outstanding,
    output int                            bytes_checked
);
    import hbp_pkg::*;

    typedef struct packed {
        logic [BYTE_BITS-1:0] bits;
        logic [BITS_W-1:0]    used;
        logic                 run_end;
        logic                 stream_end;
    } packed_byte_t;

    logic [CODE_W-1:0]    code_tab [SYMBOL_COUNT];
    logic [LEN_W-1:0]     len_tab [SYMBOL_COUNT];
    logic [BYTE_BITS-1:0] acc;
    logic [BITS_W-1:0]    fill;
    packed_byte_t         due_bytes [$];

    initial begin
        mismatches    = 0;
        outstanding   = 0;
        bytes_checked = 0;
    end

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    endtask

    task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                              input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] len_sat;
        len_sat = (int'(len) > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : len;
        if (int'(sym) < SYMBOL_COUNT) begin
            code_tab[sym] = code;
            len_tab[sym]  = len_sat;
        end
    endtask

    // append the code of one symbol msb first, filling the accumulator from bit 0
    task automatic pack_symbol(input logic [SYM_W-1:0] sym, input logic eod);
        packed_byte_t      held;
        logic              have;
        int                n;
        int                i;
        logic [CODE_W-1:0] code;
        have = 1'b0;
        held = '0;
        n    = 0;
        code = '0;
        if (int'(sym) < SYMBOL_COUNT && len_tab[sym] != '0) begin
            n    = int'(len_tab[sym]);
            code = code_tab[sym];
        end
        for (i = n - 1; i >= 0; i--) begin
            acc[fill[FILL_W-1:0]] = code[i];
            fill = fill + 1'b1;
            if (fill == BYTE_BITS) begin
                if (have)
                    due_bytes.push_back(held);
                held.bits       = acc;
                held.used       = BITS_W'(BYTE_BITS);
                held.run_end    = 1'b0;
                held.stream_end = 1'b0;
                have = 1'b1;
                acc  = '0;
                fill = '0;
            end
        end
        if (eod && fill != '0) begin
            if (have)
                due_bytes.push_back(held);
            held.bits       = acc;
            held.used       = fill;
            held.run_end    = 1'b0;
            held.stream_end = 1'b0;
            have = 1'b1;
            acc  = '0;
            fill = '0;
        end
        // last byte of the request carries the marks
        if (have) begin
            held.run_end    = 1'b1;
            held.stream_end = eod;
            due_bytes.push_back(held);
        end
    endtask

    always @(posedge aclk) begin : watch
        packed_byte_t want;
        int i;
        if (!aresetn) begin
            for (i = 0; i < SYMBOL_COUNT; i++)
                len_tab[i] = '0;
            acc  = '0;
            fill = '0;
            due_bytes.delete();
        end else begin
            // results first, so a request taken on the same edge cannot be matched early
            if (m_valid && m_ready) begin
                bytes_checked++;
                if (due_bytes.size() == 0) begin
                    report("unexpected byte", 32'(m_out_byte), 32'(m_bits_used));
                end else begin
                    want = due_bytes.pop_front();
                    if (m_out_byte !== want.bits)
                        report("out_byte", 32'(want.bits), 32'(m_out_byte));
                    if (m_bits_used !== want.used)
                        report("bits_used", 32'(want.used), 32'(m_bits_used));
                    if (m_run_last !== want.run_end)
                        report("run_last", 32'(want.run_end), 32'(m_run_last));
                    if (m_stream_last !== want.stream_end)
                        report("stream_last", 32'(want.stream_end), 32'(m_stream_last));
                end
            end
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_LOAD)
                    load_entry(s_entry_symbol, s_entry_code, s_entry_length);
                else
                    pack_symbol(s_data_byte, s_end_of_data);
            end
        end
        outstanding = due_bytes.size();
    end

endmodule

@@ tb/sv/tb_huffman_bit_packer.sv @@
`timescale 1ns / 100ps
// testbench top for the huffman bit packer: clock, reset, request and result traffic, verdict
module tb_huffman_bit_packer;
    import hbp_pkg::*;

    localparam int HOLD_CYCLES  = 60;
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 200;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_req_type;
    logic [SYM_W-1:0]     s_entry_symbol;
    logic [CODE_W-1:0]    s_entry_code;
    logic [LEN_W-1:0]     s_entry_length;
    logic [SYM_W-1:0]     s_data_byte;
    logic                 s_end_of_data;
    logic                 m_valid;
    logic                 m_ready;
    logic [BYTE_BITS-1:0] m_out_byte;
    logic [BITS_W-1:0]    m_bits_used;
    logic                 m_run_last;
    logic                 m_stream_last;

    int   mismatches;
    int   outstanding;
    int   bytes_checked;
    int   loads_sent;
    int   encodes_sent;
    int   streams_ended;
    int   idle_cycles;
    logic quiet;
    logic hold_off;

    huffman_bit_packer u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_entry_symbol (s_entry_symbol),
        .s_entry_code   (s_entry_code),
        .s_entry_length (s_entry_length),
        .s_data_byte    (s_data_byte),
        .s_end_of_data  (s_end_of_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_bits_used    (m_bits_used),
        .m_run_last     (m_run_last),
        .m_stream_last  (m_stream_last)
    );

    hbp_stream_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_entry_symbol (s_entry_symbol),
        .s_entry_code   (s_entry_code),
        .s_entry_length (s_entry_length),
        .s_data_byte    (s_data_byte),
        .s_end_of_data  (s_end_of_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_bits_used    (m_bits_used),
        .m_run_last     (m_run_last),
        .m_stream_last  (m_stream_last),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .bytes_checked  (bytes_checked)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                hold_off = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= quiet || ($urandom_range(0, 99) >= 12);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no traffic for %0d cycles, giving up", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_request(input req_t kind, input logic [SYM_W-1:0] sym,
                                input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                                input logic [SYM_W-1:0] data, input logic eod);
        if (!quiet && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= kind;
        s_entry_symbol <= sym;
        s_entry_code   <= code;
        s_entry_length <= len;
        s_data_byte    <= data;
        s_end_of_data  <= eod;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (kind == REQ_LOAD) begin
            loads_sent++;
        end else begin
            encodes_sent++;
            if (eod)
                streams_ended++;
        end
    endtask

    // data byte and end flag are don't-care on a load, so they get noise
    task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                              input logic [LEN_W-1:0] len);
        send_request(REQ_LOAD, sym, code, len, SYM_W'($urandom), 1'($urandom));
    endtask

    task automatic encode_byte(input logic [SYM_W-1:0] data, input logic eod);
        send_request(REQ_ENCODE, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom),
                     data, eod);
    endtask

    initial begin : stimulus
        logic [SYM_W-1:0] known [$];
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        int               rand_items;
        int               stream_no;
        int               n_load;
        int               n_enc;
        int               k;
        int               j;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_req_type     = REQ_LOAD;
        s_entry_symbol = '0;
        s_entry_code   = '0;
        s_entry_length = '0;
        s_data_byte    = '0;
        s_end_of_data  = 1'b0;
        quiet          = 1'b0;
        hold_off       = 1'b0;
        idle_cycles    = 0;
        loads_sent     = 0;
        encodes_sent   = 0;
        streams_ended  = 0;
        rand_items     = 0;
        stream_no      = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table, end flag with nothing pending
        encode_byte(8'h00, 1'b1);
        load_entry(8'hFF, 32'hFFFF_FFFF, 6'd32);
        load_entry(8'h80, 32'hA5A5_5A5A, 6'd63);
        load_entry(8'h01, 32'h0000_0001, 6'd1);
        load_entry(8'h7F, 32'h0000_0005, 6'd3);
        load_entry(8'h55, 32'h0000_00AA, 6'd8);
        load_entry(8'h00, 32'h1234_5678, 6'd0);
        load_entry(8'h2A, 32'h0000_0000, 6'd33);
        encode_byte(8'hFF, 1'b0);
        encode_byte(8'h80, 1'b1);
        encode_byte(8'h01, 1'b0);
        encode_byte(8'h7F, 1'b0);
        encode_byte(8'h01, 1'b1);
        // symbol with no code, then a flush triggered by it
        encode_byte(8'h00, 1'b0);
        encode_byte(8'h01, 1'b0);
        encode_byte(8'h00, 1'b1);
        // four full bytes plus a one-bit flush from a single request
        encode_byte(8'h01, 1'b0);
        encode_byte(8'hFF, 1'b1);
        encode_byte(8'h55, 1'b1);
        encode_byte(8'h2A, 1'b0);
        encode_byte(8'h00, 1'b1);

        while (rand_items < RANDOM_ITEMS) begin
            if (stream_no == 0)
                hold_off = 1'b1;
            quiet = (stream_no >= 2) && (stream_no <= 4);
            n_load = $urandom_range(1, 8);
            for (k = 0; k < n_load; k++) begin
                sym = SYM_W'($urandom_range(0, 255));
                j   = $urandom_range(0, 99);
                len = (j < 5)  ? 6'd0 :
                      (j < 10) ? LEN_W'($urandom_range(33, 63)) :
                      (j < 20) ? LEN_W'($urandom_range(13, 32)) :
                                 LEN_W'($urandom_range(1, 12));
                load_entry(sym, CODE_W'($urandom), len);
                known.push_back(sym);
                rand_items++;
            end
            n_enc = $urandom_range(4, 24);
            for (k = 0; k < n_enc; k++) begin
                // a stray table write in the middle of a stream
                if ($urandom_range(0, 99) < 8) begin
                    load_entry(SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
                    rand_items++;
                end
                if (known.size() != 0 && $urandom_range(0, 99) < 85)
                    sym = known[$urandom_range(0, known.size() - 1)];
                else
                    sym = SYM_W'($urandom_range(0, 255));
                // now and then a stream runs on into the next one unterminated
                encode_byte(sym, (k == n_enc - 1) && ($urandom_range(0, 9) != 0));
                rand_items++;
            end
            stream_no++;
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("sent %0d table loads and %0d encode requests, %0d of them ending a stream",
                 loads_sent, encodes_sent, streams_ended);
        $display("checked %0d packed bytes, %0d mismatches", bytes_checked, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
